FILE: hdl/pmq_pkg.sv
// Shared types, constants and the color-distance function of the palette quantizer.
package pmq_pkg;

    localparam int PMQ_DEPTH = 256;

    localparam int COLOR_W  = 24;
    localparam int CHAN_W   = 8;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_TOLERANCE = 2'd0;
    localparam logic [1:0] REG_OFFSET    = 2'd1;
    localparam logic [1:0] REG_LIMIT     = 2'd2;

    localparam logic [CHAN_W-1:0]  TOLERANCE_RST = 8'd0;
    localparam logic [INDEX_W-1:0] OFFSET_RST    = 8'd64;
    localparam logic [COUNT_W-1:0] LIMIT_RST     = 9'd256;

    // Token that walks down the row of cells.
    typedef struct packed {
        logic               vld;
        logic               found;
        logic [COLOR_W-1:0] color;
    } t_tok;

    // Palette write broadcast to the cells.
    typedef struct packed {
        logic               en;
        logic [COLOR_W-1:0] color;
    } t_wr;

    function automatic logic chan_close(input logic [CHAN_W-1:0] a,
                                        input logic [CHAN_W-1:0] b,
                                        input logic [CHAN_W-1:0] tol);
        logic [CHAN_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d <= tol;
    endfunction

    function automatic logic color_close(input logic [COLOR_W-1:0] a,
                                         input logic [COLOR_W-1:0] b,
                                         input logic [CHAN_W-1:0]  tol);
        return chan_close(a[7:0], b[7:0], tol) &&
               chan_close(a[15:8], b[15:8], tol) &&
               chan_close(a[23:16], b[23:16], tol);
    endfunction

endpackage

FILE: hdl/pmq_cell.sv
// One palette cell: holds one entry and passes the search token to its neighbor.
module pmq_cell
    import pmq_pkg::*;
#(
    parameter int K     = 0,
    parameter int IDX_W = 8,
    parameter int USE_W = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tok                i_tok,
    input  logic [IDX_W-1:0]    i_tok_pos,
    output t_tok                o_tok,
    output logic [IDX_W-1:0]    o_tok_pos,
    input  logic [COLOR_W-1:0]  i_pixel,
    input  logic [CHAN_W-1:0]   i_tol,
    input  logic [USE_W-1:0]    i_used,
    input  t_wr                 i_wr,
    input  logic [IDX_W-1:0]    i_wr_idx
);

    logic [COLOR_W-1:0] r_entry;
    t_tok               r_tok;
    logic [IDX_W-1:0]   r_pos;
    logic               match;

    // Only entries below the fill count take part; the others were never written.
    assign match = (USE_W'(K) < i_used) && color_close(r_entry, i_pixel, i_tol);

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == IDX_W'(K))) begin
            r_entry <= i_wr.color;
        end
    end

    // The first match along the row wins; later cells pass it on untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.found <= i_tok.found | match;
        if (!i_tok.found && match) begin
            r_tok.color <= r_entry;
            r_pos       <= IDX_W'(K);
        end else begin
            r_tok.color <= i_tok.color;
            r_pos       <= i_tok_pos;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_pos = r_pos;

endmodule

FILE: hdl/palette_match_quantizer_core.sv
// Top level of the first-fit palette quantizer: register port, cell row and result stage.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+-----------------------------------------------
//  pixel in | i_in_valid  | o_in_stall  | i_pixel_color, i_last_pixel
//  result   | o_out_valid | i_out_stall | o_palette_index, o_mapped_color, o_new_entry,
//           |             |             | o_palette_full, o_color_count, o_last_out
//  config   | psel/penable| pready      | paddr, pwrite, pwdata, prdata
//
// From acceptance a pixel passes through the start register, the search token stepping
// through one palette cell per cycle, the hold registers and the output register. One pixel
// is in work at a time; the next is taken as soon as the previous result sits in the output register.
// Reset is synchronous and empties the palette; no clearing pass is needed.
// A stalled result holds the final stage; the cell row itself never stops.
module palette_match_quantizer_core
    import pmq_pkg::*;
#(
    parameter int PALETTE_DEPTH = PMQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [COLOR_W-1:0]  i_pixel_color,
    input  logic                i_last_pixel,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [INDEX_W-1:0]  o_palette_index,
    output logic [COLOR_W-1:0]  o_mapped_color,
    output logic                o_new_entry,
    output logic                o_palette_full,
    output logic [COUNT_W-1:0]  o_color_count,
    output logic                o_last_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int USE_W = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W = (USE_W > COUNT_W) ? USE_W : COUNT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;

    // Configuration registers.
    logic [CHAN_W-1:0]  r_tol;
    logic [INDEX_W-1:0] r_offset;
    logic [COUNT_W-1:0] r_limit;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOLERANCE_RST;
            r_offset <= OFFSET_RST;
            r_limit  <= LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TOLERANCE: r_tol    <= pwdata[CHAN_W-1:0];
                REG_OFFSET:    r_offset <= pwdata[INDEX_W-1:0];
                REG_LIMIT:     r_limit  <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TOLERANCE: prdata = PDATA_W'(r_tol);
            REG_OFFSET:    prdata = PDATA_W'(r_offset);
            REG_LIMIT:     prdata = PDATA_W'(r_limit);
            default:       prdata = '0;
        endcase
    end

    // Control and result state.
    t_state               r_state, n_state;
    logic                 r_start, n_start;
    logic [USE_W-1:0]     r_used, n_used;
    logic [COLOR_W-1:0]   r_pixel, n_pixel;
    logic                 r_last, n_last;
    logic                 r_hold_found, n_hold_found;
    logic [COLOR_W-1:0]   r_hold_color, n_hold_color;
    logic [IDX_W-1:0]     r_hold_pos, n_hold_pos;
    logic                 r_out_vld, n_out_vld;
    logic [INDEX_W-1:0]   r_out_idx, n_out_idx;
    logic [COLOR_W-1:0]   r_out_color, n_out_color;
    logic                 r_out_new, n_out_new;
    logic                 r_out_full, n_out_full;
    logic [COUNT_W-1:0]   r_out_count, n_out_count;
    logic                 r_out_last, n_out_last;

    t_tok                 tok [PALETTE_DEPTH+1];
    logic [IDX_W-1:0]     tok_pos [PALETTE_DEPTH+1];
    t_wr                  wr;
    logic [IDX_W-1:0]     wr_idx;

    logic                 accept;
    logic                 slot_free;
    logic [CMP_W-1:0]     limit_sat;
    logic [CMP_W-1:0]     used_ext;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     used_after;

    assign accept    = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_vld || !i_out_stall;
    assign used_ext  = CMP_W'(r_used);
    assign limit_sat = (CMP_W'(r_limit) > CMP_W'(PALETTE_DEPTH)) ?
                       CMP_W'(PALETTE_DEPTH) : CMP_W'(r_limit);

    assign tok[0].vld   = r_start;
    assign tok[0].found = 1'b0;
    assign tok[0].color = r_pixel;
    assign tok_pos[0]   = '0;

    for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
        pmq_cell #(
            .K     (k),
            .IDX_W (IDX_W),
            .USE_W (USE_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (tok[k]),
            .i_tok_pos (tok_pos[k]),
            .o_tok     (tok[k+1]),
            .o_tok_pos (tok_pos[k+1]),
            .i_pixel   (r_pixel),
            .i_tol     (r_tol),
            .i_used    (r_used),
            .i_wr      (wr),
            .i_wr_idx  (wr_idx)
        );
    end

    always_comb begin
        n_state      = r_state;
        n_start      = 1'b0;
        n_used       = r_used;
        n_pixel      = r_pixel;
        n_last       = r_last;
        n_hold_found = r_hold_found;
        n_hold_color = r_hold_color;
        n_hold_pos   = r_hold_pos;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out_idx    = r_out_idx;
        n_out_color  = r_out_color;
        n_out_new    = r_out_new;
        n_out_full   = r_out_full;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        wr.en        = 1'b0;
        wr.color     = r_pixel;
        wr_idx       = r_used[IDX_W-1:0];
        pos_ext      = '0;
        used_after   = used_ext;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pixel = i_pixel_color;
                    n_last  = i_last_pixel;
                    n_start = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (tok[PALETTE_DEPTH].vld) begin
                    n_hold_found = tok[PALETTE_DEPTH].found;
                    n_hold_color = tok[PALETTE_DEPTH].color;
                    n_hold_pos   = tok_pos[PALETTE_DEPTH];
                    n_state      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_out_new   = 1'b0;
                    n_out_full  = 1'b0;
                    n_out_color = r_pixel;
                    if (r_hold_found) begin
                        pos_ext     = CMP_W'(r_hold_pos);
                        n_out_color = r_hold_color;
                    end else if (used_ext < limit_sat) begin
                        // Append: the fill count is below the limit, so it fits the index.
                        wr.en      = 1'b1;
                        pos_ext    = used_ext;
                        used_after = used_ext + CMP_W'(1);
                        n_out_new  = 1'b1;
                    end else begin
                        n_out_full = 1'b1;
                    end
                    n_out_idx   = r_offset + pos_ext[INDEX_W-1:0];
                    n_out_count = used_after[COUNT_W-1:0];
                    n_out_last  = r_last;
                    n_out_vld   = 1'b1;
                    n_used      = r_last ? '0 : used_after[USE_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start   <= 1'b0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_start   <= n_start;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
        end
        r_pixel      <= n_pixel;
        r_last       <= n_last;
        r_hold_found <= n_hold_found;
        r_hold_color <= n_hold_color;
        r_hold_pos   <= n_hold_pos;
        r_out_idx    <= n_out_idx;
        r_out_color  <= n_out_color;
        r_out_new    <= n_out_new;
        r_out_full   <= n_out_full;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_palette_index = r_out_idx;
    assign o_mapped_color  = r_out_color;
    assign o_new_entry     = r_out_new;
    assign o_palette_full  = r_out_full;
    assign o_color_count   = r_out_count;
    assign o_last_out      = r_out_last;

endmodule

FILE: hdl/pmq_checker.sv
// Port-level checks of the palette quantizer, bound to the top level.
module pmq_checker
    import pmq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [INDEX_W-1:0]  o_palette_index,
    input logic [COLOR_W-1:0]  o_mapped_color,
    input logic                o_new_entry,
    input logic                o_palette_full,
    input logic [COUNT_W-1:0]  o_color_count
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_palette_index) &&
        $stable(o_mapped_color) && $stable(o_color_count))
        else $error("result beat changed while stalled");

    // Appending and refusing a pixel exclude each other.
    a_new_or_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_new_entry && o_palette_full))
        else $error("pixel flagged both appended and refused");

    // An appended pixel is counted in the palette.
    a_new_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_entry |-> o_color_count != '0)
        else $error("new entry reported with an empty palette");

    // After a pixel beat the search is under way, so no second pixel is taken at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("pixel accepted while a search was running");

endmodule

bind palette_match_quantizer_core pmq_checker u_pmq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_palette_index (o_palette_index),
    .o_mapped_color  (o_mapped_color),
    .o_new_entry     (o_new_entry),
    .o_palette_full  (o_palette_full),
    .o_color_count   (o_color_count)
);
